// ===== hdl/bqdo_pkg.sv =====
// ----------------------------------------------------------------------------
// bqdo_pkg
// Shared types and constants for the bounded drop-oldest record queue:
// operation codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package bqdo_pkg;

  localparam int OP_W           = 2;
  localparam int OCC_W          = 11;
  localparam int TAKE_W         = 7;
  localparam int CAP_RESET      = 1024;
  localparam int DEF_DEPTH      = 1024;
  localparam int DEF_RECORD_W   = 32;
  localparam int DEF_MAX_BURST  = 64;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_TAKE   = 2'd1,
    OP_RETURN = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TRIM,
    ST_EMIT,
    ST_TAKE_RD,
    ST_TAKE_WR
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic exec;
    logic trim;
    logic rd;
    logic load_info;
    logic load_take;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic trim_req;
    logic take_none;
    logic last;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/bounded_queue_drop_oldest_top.sv =====
// ----------------------------------------------------------------------------
// bounded_queue_drop_oldest_top
// Record queue with a run-time capacity that discards its oldest records.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready: push at tail, take up to
// in_take_count records from the head, or return one record to the head.
// Results leave on out_valid/out_ready from a result register; each
// carries occupancy and empty flags, takes mark their final record.
// cfg_write_en/cfg_write_data set the capacity (0 acts as 1, values above
// DEPTH act as DEPTH); write only while idle.
// Sequencing: a request is taken in idle only. Push, return, no-op and
// empty take run execute, a head trim when needed, then the result load.
// A take of n records runs execute and a first memory read, then streams
// one record per cycle unless stalled, paced by the registered memory read port.
// A stalled receiver holds the result register; the take stream pauses
// and the next request waits until the current one has loaded its final
// result into the result register.
// Reset empties the queue (head, tail, count cleared) and sets capacity to
// 1024 (DEPTH if smaller); the memory contents are not cleared.
// ----------------------------------------------------------------------------
module bounded_queue_drop_oldest_top
  import bqdo_pkg::*;
#(
  parameter int DEPTH        = DEF_DEPTH,
  parameter int RECORD_WIDTH = DEF_RECORD_W,
  parameter int MAX_BURST    = DEF_MAX_BURST
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [OP_W-1:0]         in_operation,
  input  logic [RECORD_WIDTH-1:0] in_record_in,
  input  logic [TAKE_W-1:0]       in_take_count,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [RECORD_WIDTH-1:0] out_record_out,
  output logic                    out_record_valid,
  output logic                    out_last_of_burst,
  output logic                    out_dropped,
  output logic [OCC_W-1:0]        out_occupancy,
  output logic                    out_is_empty,
  input  logic                    cfg_write_en,
  input  logic [OCC_W-1:0]        cfg_write_data
);

  cmd_t cmd;
  sts_t sts;

  bqdo_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bqdo_dp #(
    .DEPTH        (DEPTH),
    .RECORD_WIDTH (RECORD_WIDTH),
    .MAX_BURST    (MAX_BURST)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_operation      (in_operation),
    .in_record_in      (in_record_in),
    .in_take_count     (in_take_count),
    .cfg_write_en      (cfg_write_en),
    .cfg_write_data    (cfg_write_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_record_out    (out_record_out),
    .out_record_valid  (out_record_valid),
    .out_last_of_burst (out_last_of_burst),
    .out_dropped       (out_dropped),
    .out_occupancy     (out_occupancy),
    .out_is_empty      (out_is_empty)
  );

endmodule

// ===== hdl/bqdo_ctrl.sv =====
// ----------------------------------------------------------------------------
// bqdo_ctrl
// Controller state machine: sequences one request through execute, trim,
// result and take-streaming steps and drives the datapath commands.
// ----------------------------------------------------------------------------
module bqdo_ctrl
  import bqdo_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.op == OP_TAKE && !sts.take_none) state_nxt = ST_TAKE_RD;
        else if (sts.trim_req)                    state_nxt = ST_TRIM;
        else                                      state_nxt = ST_EMIT;
      end
      ST_TRIM: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      ST_TAKE_RD: state_nxt = ST_TAKE_WR;
      ST_TAKE_WR: begin
        if (sts.out_free && sts.last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      ST_EXEC:    cmd.exec = 1'b1;
      ST_TRIM:    cmd.trim = 1'b1;
      ST_EMIT:    cmd.load_info = sts.out_free;
      ST_TAKE_RD: cmd.rd = 1'b1;
      ST_TAKE_WR: begin
        cmd.load_take = sts.out_free;
        cmd.rd        = sts.out_free && !sts.last;
      end
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/bqdo_dp.sv =====
// ----------------------------------------------------------------------------
// bqdo_dp
// Datapath: record memory, head/tail pointers, occupancy and capacity
// registers, burst counter and the registered result stage.
// ----------------------------------------------------------------------------
module bqdo_dp
  import bqdo_pkg::*;
#(
  parameter int DEPTH        = DEF_DEPTH,
  parameter int RECORD_WIDTH = DEF_RECORD_W,
  parameter int MAX_BURST    = DEF_MAX_BURST
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  input  logic [OP_W-1:0]         in_operation,
  input  logic [RECORD_WIDTH-1:0] in_record_in,
  input  logic [TAKE_W-1:0]       in_take_count,
  input  logic                    cfg_write_en,
  input  logic [OCC_W-1:0]        cfg_write_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [RECORD_WIDTH-1:0] out_record_out,
  output logic                    out_record_valid,
  output logic                    out_last_of_burst,
  output logic                    out_dropped,
  output logic [OCC_W-1:0]        out_occupancy,
  output logic                    out_is_empty
);

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BURST_W = (MAX_BURST > 1) ? $clog2(MAX_BURST + 1) : 1;
  localparam int SUM_W   = ((PTR_W > OCC_W) ? PTR_W : OCC_W) + 2;
  localparam int CAP_MAX = (DEPTH < 2047) ? DEPTH : 2047;
  localparam int CAP_RST = (CAP_RESET < DEPTH) ? CAP_RESET : DEPTH;
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);

  logic [RECORD_WIDTH-1:0] mem [DEPTH];

  op_t                     op_r;
  logic [RECORD_WIDTH-1:0] rec_r;
  logic [BURST_W-1:0]      n_r;
  logic [OCC_W-1:0]        cap_r;
  logic [PTR_W-1:0]        head_r, head_nxt;
  logic [PTR_W-1:0]        tail_r, tail_nxt;
  logic [OCC_W-1:0]        cnt_r, cnt_nxt;
  logic [OCC_W:0]          excess_r, excess_nxt;
  logic                    drop_r, drop_nxt;
  logic [BURST_W-1:0]      rem_r, rem_nxt;
  logic [RECORD_WIDTH-1:0] rd_data_r;
  logic                    out_valid_r;
  logic [RECORD_WIDTH-1:0] out_rec_r;
  logic                    out_rv_r, out_last_r, out_drop_r, out_empty_r;
  logic [OCC_W-1:0]        out_occ_r;

  logic [OCC_W:0]          cnt_inc, cap_x;
  logic                    push_over, ret_full, ret_over;
  logic [BURST_W-1:0]      n_eff;
  logic [TAKE_W-1:0]       take_clamped;
  logic [PTR_W-1:0]        head_inc, head_dec, tail_inc, head_trim;
  logic [SUM_W-1:0]        head_sum;
  logic                    mem_we;
  logic [PTR_W-1:0]        mem_waddr;
  logic                    out_free;

  assign cnt_inc   = {1'b0, cnt_r} + (OCC_W+1)'(1);
  assign cap_x     = {1'b0, cap_r};
  assign push_over = cnt_inc > cap_x;
  assign ret_full  = cnt_r >= cap_r;
  assign ret_over  = cnt_r > cap_r;
  assign n_eff     = (OCC_W'(n_r) > cnt_r) ? BURST_W'(cnt_r) : n_r;

  assign take_clamped = (in_take_count > TAKE_W'(MAX_BURST)) ? TAKE_W'(MAX_BURST)
                                                             : in_take_count;

  assign head_inc  = (head_r == LAST_IDX) ? '0 : head_r + PTR_W'(1);
  assign head_dec  = (head_r == '0) ? LAST_IDX : head_r - PTR_W'(1);
  assign tail_inc  = (tail_r == LAST_IDX) ? '0 : tail_r + PTR_W'(1);
  assign head_sum  = SUM_W'(head_r) + SUM_W'(excess_r);
  assign head_trim = (head_sum >= SUM_W'(DEPTH)) ? PTR_W'(head_sum - SUM_W'(DEPTH))
                                                 : PTR_W'(head_sum);

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    sts.op        = op_r;
    sts.trim_req  = (op_r == OP_PUSH) ? push_over :
                    (op_r == OP_RETURN) ? ret_over : 1'b0;
    sts.take_none = (n_eff == '0);
    sts.last      = (rem_r == '0);
    sts.out_free  = out_free;
  end

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cnt_nxt    = cnt_r;
    excess_nxt = excess_r;
    drop_nxt   = drop_r;
    rem_nxt    = rem_r;
    mem_we     = 1'b0;
    mem_waddr  = tail_r;
    if (cmd.exec) begin
      drop_nxt = 1'b0;
      case (op_r)
        OP_PUSH: begin
          mem_we   = 1'b1;
          tail_nxt = tail_inc;
          if (push_over) begin
            excess_nxt = cnt_inc - cap_x;
            cnt_nxt    = cap_r;
            drop_nxt   = 1'b1;
          end else begin
            cnt_nxt = OCC_W'(cnt_inc);
          end
        end
        OP_RETURN: begin
          if (ret_full) begin
            drop_nxt   = 1'b1;
            excess_nxt = {1'b0, cnt_r} - cap_x;
            cnt_nxt    = cap_r;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = head_dec;
            head_nxt  = head_dec;
            cnt_nxt   = OCC_W'(cnt_inc);
          end
        end
        OP_TAKE: rem_nxt = n_eff;
        default: drop_nxt = 1'b0;
      endcase
    end
    if (cmd.trim) begin
      head_nxt = head_trim;
    end
    if (cmd.rd) begin
      head_nxt = head_inc;
      cnt_nxt  = cnt_r - OCC_W'(1);
      rem_nxt  = rem_r - BURST_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= rec_r;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      cap_r       <= OCC_W'(CAP_RST);
      rem_r       <= '0;
      drop_r      <= 1'b0;
      excess_r    <= '0;
      op_r        <= OP_NOP;
      out_valid_r <= 1'b0;
    end else begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      cnt_r    <= cnt_nxt;
      rem_r    <= rem_nxt;
      drop_r   <= drop_nxt;
      excess_r <= excess_nxt;
      if (cfg_write_en) begin
        if (cfg_write_data == '0) begin
          cap_r <= OCC_W'(1);
        end else if (32'(cfg_write_data) > 32'(CAP_MAX)) begin
          cap_r <= OCC_W'(CAP_MAX);
        end else begin
          cap_r <= cfg_write_data;
        end
      end
      if (cmd.latch_in) begin
        op_r <= op_t'(in_operation);
      end
      if (cmd.load_info || cmd.load_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      rec_r <= in_record_in;
      n_r   <= BURST_W'(take_clamped);
    end
    if (cmd.load_info) begin
      out_rec_r   <= '0;
      out_rv_r    <= 1'b0;
      out_last_r  <= 1'b1;
      out_drop_r  <= drop_r;
      out_occ_r   <= cnt_r;
      out_empty_r <= (cnt_r == '0);
    end else if (cmd.load_take) begin
      out_rec_r   <= rd_data_r;
      out_rv_r    <= 1'b1;
      out_last_r  <= (rem_r == '0);
      out_drop_r  <= 1'b0;
      out_occ_r   <= cnt_r;
      out_empty_r <= (cnt_r == '0);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_record_out    = out_rec_r;
  assign out_record_valid  = out_rv_r;
  assign out_last_of_burst = out_last_r;
  assign out_dropped       = out_drop_r;
  assign out_occupancy     = out_occ_r;
  assign out_is_empty      = out_empty_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= 32'(DEPTH))
    else $error("occupancy exceeds memory depth");

  a_rd_legal: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |-> (cnt_r != '0) && (rem_r != '0))
    else $error("read beyond occupancy or burst");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_info || cmd.load_take) |-> out_free)
    else $error("result overwritten while pending");

  a_take_stream: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_take |=> out_valid_r && out_rv_r)
    else $error("taken record not presented");

endmodule
